>>> hw/rtl/assert_macros.svh
// Assertion macros used by the port-level checker of the allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator check failed");

// Next-cycle implication, disabled while rst is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator check failed");

`endif

>>> hw/rtl/bsa_pkg.sv
// Package of types, codes and defaults for the bitmap slot allocator.
package bsa_pkg;

   localparam int NUM_SLOTS_DEF = 256;
   localparam int WORD_BITS_DEF = 32;

   localparam int SLOT_COUNT_W  = 9;
   localparam int OBJECT_SIZE_W = 16;
   localparam int SLOT_INDEX_W  = 8;
   localparam int OFFSET_W      = 24;
   localparam int CSR_DATA_W    = 16;
   localparam int CSR_INDEX_W   = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_SLOT_COUNT  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OBJECT_SIZE = 1'd1;

   localparam logic [SLOT_COUNT_W-1:0]  SLOT_COUNT_RST  = 9'd256;
   localparam logic [OBJECT_SIZE_W-1:0] OBJECT_SIZE_RST = 16'd1;

   localparam logic [1:0] CMD_ALLOC       = 2'd0;
   localparam logic [1:0] CMD_RELEASE     = 2'd1;
   localparam logic [1:0] CMD_RELEASE_ALL = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   typedef struct packed {
      logic [1:0]              command;
      logic [SLOT_INDEX_W-1:0] slot_index;
   } req_type;

   typedef struct packed {
      logic                    granted;
      logic [SLOT_INDEX_W-1:0] given_index;
      logic [OFFSET_W-1:0]     byte_offset;
      logic [1:0]              status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MULT,
      ST_RELEASE,
      ST_CLEAR
   } state_type;

endpackage

>>> hw/rtl/bsa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bsa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/bitmap_slot_allocator_core.sv
// Top level of the first-fit bitmap slot allocator: sequencer, map RAM and result register.
// Allocate: busy over the map words examined (1 to MAP_WORDS, eight at defaults), plus the
//    multiply state if granted, none for a zero slot count; result strobed in the cycle after.
// Release: busy in its own state, none if out of range. Release-all: busy over all map words.
// Invalid command: no busy time. The rate is set by the map RAM's one word read per cycle.
// Reset (synchronous) starts a clearing sweep of all map words with busy high.
// The result transfer cannot be stalled; a new start is taken while a result is shown.
module bitmap_slot_allocator_core
   import bsa_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF,
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  req_type                  req_data,
   output logic                     rsp_strobe,
   output rsp_type                  rsp_data,
   input  logic                     csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wr_data
);

   // Map geometry. Slot k lives at bit k % WORD_BITS of word k / WORD_BITS.
   localparam int MAP_WORDS = (NUM_SLOTS + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int SLOT_W    = $clog2(NUM_SLOTS);
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int SPAN      = MAP_WORDS * WORD_BITS;
   // Width for slot counts, word base indexes and their comparisons.
   localparam int CMP_W     = ($clog2(SPAN + 1) > SLOT_COUNT_W) ?
                              $clog2(SPAN + 1) : SLOT_COUNT_W;
   localparam int PROD_W    = SLOT_W + OBJECT_SIZE_W;
   localparam int REL_SPAN  = 1 << SLOT_INDEX_W;

   // Control and configuration registers.
   state_type                state_ff, state_in;
   logic [ADDR_W-1:0]        word_ptr_ff, word_ptr_in;
   logic                     clr_rsp_ff, clr_rsp_in;
   logic                     rsp_strobe_ff, rsp_strobe_in;
   logic [SLOT_COUNT_W-1:0]  slot_count_ff;
   logic [OBJECT_SIZE_W-1:0] object_size_ff;

   // Datapath registers.
   logic [CMP_W-1:0]         base_ff, base_in;
   logic [SLOT_W-1:0]        slot_ff, slot_in;
   logic [BIT_W-1:0]         rel_bit_ff, rel_bit_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   // Map RAM ports.
   logic                     ram_wr_en;
   logic [ADDR_W-1:0]        ram_wr_addr;
   logic [WORD_BITS-1:0]     ram_wr_data;
   logic [ADDR_W-1:0]        ram_rd_addr;
   logic [WORD_BITS-1:0]     ram_rd_data;

   // Decode and search signals.
   logic                     accept;
   logic [CMP_W-1:0]         live_count;
   logic                     rel_in_range;
   logic [ADDR_W-1:0]        rel_word_tbl [REL_SPAN];
   logic [BIT_W-1:0]         rel_bit_tbl  [REL_SPAN];
   logic [ADDR_W-1:0]        next_ptr;
   logic                     last_ptr;
   logic [CMP_W-1:0]         remain;
   logic [WORD_BITS-1:0]     valid_mask;
   logic [WORD_BITS-1:0]     free_mask;
   logic [WORD_BITS-1:0]     low_bit;
   logic                     found;
   logic [BIT_W-1:0]         bit_idx;
   logic                     last_word;
   logic [PROD_W-1:0]        product;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // The effective slot count saturates at the number of slots the map holds.
   assign live_count = (CMP_W'(slot_count_ff) > CMP_W'(NUM_SLOTS)) ?
                       CMP_W'(NUM_SLOTS) : CMP_W'(slot_count_ff);
   assign rel_in_range = CMP_W'(req_data.slot_index) < live_count;

   // Constant tables that split a release index into map word and bit position.
   for (genvar g = 0; g < REL_SPAN; g++) begin : g_rel_tbl
      assign rel_word_tbl[g] = ADDR_W'(g / WORD_BITS);
      assign rel_bit_tbl[g]  = BIT_W'(g % WORD_BITS);
   end

   assign last_ptr = (word_ptr_ff == ADDR_W'(MAP_WORDS - 1));
   assign next_ptr = last_ptr ? '0 : word_ptr_ff + 1'b1;

   // Search of the word read this cycle: only slots below the live count are candidates.
   assign remain    = live_count - base_ff;
   assign last_word = (base_ff + CMP_W'(WORD_BITS)) >= live_count;

   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         valid_mask[b] = CMP_W'(b) < remain;
      end
   end

   assign free_mask = ~ram_rd_data & valid_mask;
   assign low_bit   = free_mask & (~free_mask + 1'b1);
   assign found     = |free_mask;

   always_comb begin
      bit_idx = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         if (low_bit[b]) begin
            bit_idx = bit_idx | BIT_W'(b);
         end
      end
   end

   // Byte offset of the claimed slot; the product is registered in the result register.
   assign product = PROD_W'(slot_ff) * PROD_W'(object_size_ff);

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.command)
                  CMD_ALLOC: begin
                     if (live_count != '0) begin
                        state_in = ST_SCAN;
                     end
                  end
                  CMD_RELEASE: begin
                     if (rel_in_range) begin
                        state_in = ST_RELEASE;
                     end
                  end
                  CMD_RELEASE_ALL: begin
                     state_in = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (found) begin
               state_in = ST_MULT;
            end else if (last_word) begin
               state_in = ST_IDLE;
            end
         end
         ST_MULT: begin
            state_in = ST_IDLE;
         end
         ST_RELEASE: begin
            state_in = ST_IDLE;
         end
         ST_CLEAR: begin
            if (last_ptr) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath, RAM and result control for each state.
   always_comb begin
      word_ptr_in   = word_ptr_ff;
      base_in       = base_ff;
      slot_in       = slot_ff;
      rel_bit_in    = rel_bit_ff;
      clr_rsp_in    = clr_rsp_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = '0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = word_ptr_ff;
      ram_wr_data   = '0;
      ram_rd_addr   = word_ptr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            // Fetch the first word an incoming command needs, so it is ready next cycle.
            ram_rd_addr = (req_data.command == CMD_RELEASE) ?
                          rel_word_tbl[req_data.slot_index] : '0;
            if (accept) begin
               unique case (req_data.command)
                  CMD_ALLOC: begin
                     word_ptr_in = '0;
                     base_in     = '0;
                     if (live_count == '0) begin
                        rsp_strobe_in      = 1'b1;
                        rsp_data_in.status = STATUS_FULL;
                     end
                  end
                  CMD_RELEASE: begin
                     word_ptr_in = rel_word_tbl[req_data.slot_index];
                     rel_bit_in  = rel_bit_tbl[req_data.slot_index];
                     if (!rel_in_range) begin
                        rsp_strobe_in      = 1'b1;
                        rsp_data_in.status = STATUS_RANGE;
                     end
                  end
                  CMD_RELEASE_ALL: begin
                     word_ptr_in = '0;
                     clr_rsp_in  = 1'b1;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // Check the current word while the next one is read.
            ram_rd_addr = next_ptr;
            if (found) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = ram_rd_data | low_bit;
               slot_in     = SLOT_W'(base_ff + CMP_W'(bit_idx));
            end else if (last_word) begin
               rsp_strobe_in      = 1'b1;
               rsp_data_in.status = STATUS_FULL;
            end else begin
               word_ptr_in = next_ptr;
               base_in     = base_ff + CMP_W'(WORD_BITS);
            end
         end
         ST_MULT: begin
            rsp_strobe_in           = 1'b1;
            rsp_data_in.granted     = 1'b1;
            rsp_data_in.given_index = SLOT_INDEX_W'(slot_ff);
            rsp_data_in.byte_offset = OFFSET_W'(product);
            rsp_data_in.status      = STATUS_OK;
         end
         ST_RELEASE: begin
            ram_wr_en          = 1'b1;
            ram_wr_data        = ram_rd_data & ~(WORD_BITS'(1) << rel_bit_ff);
            rsp_strobe_in      = 1'b1;
            rsp_data_in.status = STATUS_OK;
         end
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            word_ptr_in = next_ptr;
            // Only a release-all sweep answers; the sweep after reset does not.
            if (last_ptr && clr_rsp_ff) begin
               rsp_strobe_in      = 1'b1;
               rsp_data_in.status = STATUS_OK;
               clr_rsp_in         = 1'b0;
            end
         end
         default: begin
            rsp_strobe_in = 1'b0;
         end
      endcase
   end

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         word_ptr_ff    <= '0;
         clr_rsp_ff     <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
         slot_count_ff  <= SLOT_COUNT_RST;
         object_size_ff <= OBJECT_SIZE_RST;
      end else begin
         state_ff      <= state_in;
         word_ptr_ff   <= word_ptr_in;
         clr_rsp_ff    <= clr_rsp_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_SLOT_COUNT:  slot_count_ff  <= csr_wr_data[SLOT_COUNT_W-1:0];
               CSR_OBJECT_SIZE: object_size_ff <= csr_wr_data[OBJECT_SIZE_W-1:0];
               default:         slot_count_ff  <= slot_count_ff;
            endcase
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      slot_ff     <= slot_in;
      rel_bit_ff  <= rel_bit_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Used map, one word per WORD_BITS slots.
   bsa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MAP_WORDS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

>>> hw/rtl/bsa_checker.sv
// Port-level checker for the bitmap slot allocator, bound to the top level.
`include "assert_macros.svh"

module bsa_checker
   import bsa_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   logic slot_fields_zero;
   logic status_ok;

   assign slot_fields_zero = (rsp_data.given_index == '0) && (rsp_data.byte_offset == '0);
   assign status_ok        = (rsp_data.status == STATUS_OK);

   `ASSERT_NEXT(a_reset_sweeps, clock, 1'b0, reset, busy && !rsp_strobe)
   `ASSERT_IMPLY(a_result_when_idle, clock, reset, rsp_strobe, !busy)
   `ASSERT_NEXT(a_start_progresses, clock, reset, start && !busy, busy || rsp_strobe)
   `ASSERT_IMPLY(a_ungranted_zero, clock, reset, rsp_strobe && !rsp_data.granted, slot_fields_zero)
   `ASSERT_IMPLY(a_grant_ok, clock, reset, rsp_strobe && rsp_data.granted, status_ok)

endmodule

bind bitmap_slot_allocator_core bsa_checker u_bsa_checker (.*);

>>> verif/bitmap_slot_allocator_core_test.sv
// Self-checking testbench for the first-fit bitmap slot allocator core.
module bitmap_slot_allocator_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import bsa_pkg::*;

   // The command encoding leaves code 3 unused; the block must answer it with an all-zero result.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Each map word holds WORD_BITS_DEF slot bits, but the shadow map below is kept
   // flat, one bit per slot, which is all the first-fit search needs.
   localparam int LIVE_MAX = NUM_SLOTS_DEF;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   start       = 1'b0;
   logic                   busy;
   req_type                req_data    = '0;
   logic                   rsp_strobe;
   rsp_type                rsp_data;
   logic                   csr_wr_en   = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_wr_data = '0;

   bitmap_slot_allocator_core u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #4 clock = ~clock;

   // Shadow copy of the allocator: the used map and both registers at their reset values.
   logic [LIVE_MAX-1:0]      used_slots     = '0;
   logic [SLOT_COUNT_W-1:0]  slot_count_sh  = SLOT_COUNT_RST;
   logic [OBJECT_SIZE_W-1:0] object_size_sh = OBJECT_SIZE_RST;

   // Results predicted for accepted commands, oldest first. Every command yields exactly one.
   rsp_type outcome_q[$];

   int errors      = 0;
   int item_count  = 0;
   int n_granted   = 0;
   int n_full      = 0;
   int n_range     = 0;
   int top_offset  = 0;

   // One row of the directed script: either a register write or a command. A command row
   // may carry a typed-in result; otherwise its result comes from the shadow allocator.
   typedef struct {
      bit                     is_csr;
      logic [CSR_INDEX_W-1:0] reg_idx;
      logic [CSR_DATA_W-1:0]  reg_val;
      req_type                req;
      bit                     typed;
      rsp_type                rsp;
   } step_row;

   // One random phase: register settings, the share of allocates, and the number of commands.
   // A negative object size asks for a random one.
   typedef struct {
      int count;
      int size;
      int alloc_pct;
      int items;
   } phase_row;

   // The slot count saturates at the number of physical slots.
   function automatic int unsigned live_slots();
      return (slot_count_sh > LIVE_MAX) ? LIVE_MAX : slot_count_sh;
   endfunction

   // Applies one command to the shadow map and returns the result the block must give.
   function automatic rsp_type slot_outcome(input req_type r);
      rsp_type     o;
      int unsigned live;
      bit          found;
      o     = '0;
      live  = live_slots();
      found = 1'b0;
      case (r.command)
         CMD_ALLOC: begin
            // First fit: lowest clear bit below the live count; full when none is left.
            o.status = STATUS_FULL;
            for (int k = 0; k < live && !found; k++) begin
               if (!used_slots[k]) begin
                  used_slots[k] = 1'b1;
                  found         = 1'b1;
                  o.granted     = 1'b1;
                  o.given_index = 8'(k);
                  o.byte_offset = OFFSET_W'(k * object_size_sh);
                  o.status      = STATUS_OK;
               end
            end
         end
         CMD_RELEASE: begin
            // Releasing a free slot is harmless; only an index past the live count is an error.
            if (r.slot_index < live) used_slots[r.slot_index] = 1'b0;
            else o.status = STATUS_RANGE;
         end
         CMD_RELEASE_ALL: begin
            // Clears the whole map, including bits above the current slot count.
            used_slots = '0;
         end
         default: begin
         end
      endcase
      return o;
   endfunction

   function automatic step_row row_item(input logic [1:0] c, input logic [7:0] i);
      step_row s;
      s                = '{default: '0};
      s.req.command    = c;
      s.req.slot_index = i;
      return s;
   endfunction

   function automatic step_row row_checked(input logic [1:0] c, input logic [7:0] i,
                                           input logic g, input logic [7:0] gi,
                                           input logic [23:0] off, input logic [1:0] st);
      step_row s;
      s                 = row_item(c, i);
      s.typed           = 1'b1;
      s.rsp.granted     = g;
      s.rsp.given_index = gi;
      s.rsp.byte_offset = off;
      s.rsp.status      = st;
      return s;
   endfunction

   function automatic step_row row_csr(input logic [CSR_INDEX_W-1:0] idx,
                                       input logic [CSR_DATA_W-1:0] val);
      step_row s;
      s         = '{default: '0};
      s.is_csr  = 1'b1;
      s.reg_idx = idx;
      s.reg_val = val;
      return s;
   endfunction

   // The sender idles rarely for the first 500 commands, often for the next 500, never after.
   function automatic int sender_idle_pct();
      if (item_count < 500) return 11;
      if (item_count < 1000) return 84;
      return 0;
   endfunction

   // Random command mix: mostly allocates and in-range releases, with some out-of-range
   // releases, an occasional release-all and an occasional unused code.
   function automatic req_type random_req(input int alloc_pct);
      req_type     r;
      int          roll;
      int unsigned live;
      live         = live_slots();
      roll         = $urandom_range(99);
      r.slot_index = 8'($urandom_range(255));
      if (roll < alloc_pct) begin
         r.command = CMD_ALLOC;
      end else if (roll < 96) begin
         r.command = CMD_RELEASE;
         if (live > 0 && $urandom_range(3) != 0) r.slot_index = 8'($urandom_range(live - 1));
      end else if (roll < 98) begin
         r.command = CMD_RELEASE_ALL;
      end else begin
         r.command = CMD_UNUSED;
      end
      return r;
   endfunction

   // Offers one command and holds it until the block takes it. The caller is at a rising
   // edge. The command is taken at the first edge where start is high and busy is low;
   // busy is read right after the edge, so it still shows its value from before the edge.
   task automatic send_item(input req_type r, input bit typed, input rsp_type typed_rsp);
      rsp_type p;
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      p = slot_outcome(r);
      outcome_q.push_back(typed ? typed_rsp : p);
      item_count++;
   endtask

   // Random gap after a transfer. When there is no gap, start stays high for the next
   // command, so it is never lowered and raised again at the same edge.
   task automatic idle_gap(input int pct);
      if (pct > 0 && $urandom_range(99) < pct) begin
         start    <= 1'b0;
         req_data <= req_type'($urandom);
         do @(posedge clock); while ($urandom_range(99) < pct);
      end
   endtask

   // Holds the sender off until every outstanding result has come back and the block is idle.
   task automatic drain_outcomes();
      start <= 1'b0;
      while (outcome_q.size() != 0 || busy) @(posedge clock);
   endtask

   // Register writes happen only while the block is idle. The shadow copy takes the same
   // truncation to register width that the block applies.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      drain_outcomes();
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      if (idx == CSR_SLOT_COUNT) slot_count_sh = val[SLOT_COUNT_W-1:0];
      else object_size_sh = val[OBJECT_SIZE_W-1:0];
      // The enable is sampled low before the next write can raise it.
      @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   // Result checker. A result transfer completes at the edge that ends its strobe cycle; the
   // outputs are read right after the edge, before the block updates them.
   rsp_type want;
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (outcome_q.size() == 0) begin
            $display("%0t ns: result with nothing expected, expected none, actual %0h",
                     $time, rsp_data);
            errors++;
         end else begin
            want = outcome_q.pop_front();
            check_field("granted", 32'(want.granted), 32'(rsp_data.granted));
            check_field("given_index", 32'(want.given_index), 32'(rsp_data.given_index));
            check_field("byte_offset", 32'(want.byte_offset), 32'(rsp_data.byte_offset));
            check_field("status", 32'(want.status), 32'(rsp_data.status));
         end
         if (rsp_data.granted === 1'b1) n_granted++;
         if (rsp_data.status === STATUS_FULL) n_full++;
         if (rsp_data.status === STATUS_RANGE) n_range++;
         if (int'(rsp_data.byte_offset) > top_offset) top_offset = int'(rsp_data.byte_offset);
      end
   end

   initial begin : stimulus
      step_row  script[$];
      phase_row phases[$];
      rsp_type  unused_rsp;
      int       drain_wait;
      unused_rsp = '0;

      // Directed script. After reset all 256 slots are live and each slot is one byte.
      script = {
         row_checked(CMD_ALLOC, 8'h00, 1'b1, 8'd0, 24'd0, STATUS_OK),
         row_checked(CMD_ALLOC, 8'hFF, 1'b1, 8'd1, 24'd1, STATUS_OK),
         row_checked(CMD_RELEASE, 8'h00, 1'b0, 8'd0, 24'd0, STATUS_OK),
         // A slot that is already free releases cleanly.
         row_checked(CMD_RELEASE, 8'h00, 1'b0, 8'd0, 24'd0, STATUS_OK),
         row_item(CMD_ALLOC, 8'h55),
         row_checked(CMD_RELEASE, 8'hFF, 1'b0, 8'd0, 24'd0, STATUS_OK),
         // The unused command changes nothing and answers with all fields zero.
         row_checked(CMD_UNUSED, 8'hFF, 1'b0, 8'd0, 24'd0, STATUS_OK),
         row_checked(CMD_RELEASE_ALL, 8'hAA, 1'b0, 8'd0, 24'd0, STATUS_OK),
         // Largest object size with a single live slot: the second allocate finds it full.
         row_csr(CSR_OBJECT_SIZE, 16'hFFFF),
         row_csr(CSR_SLOT_COUNT, 16'd1),
         row_checked(CMD_ALLOC, 8'h00, 1'b1, 8'd0, 24'd0, STATUS_OK),
         row_checked(CMD_ALLOC, 8'h00, 1'b0, 8'd0, 24'd0, STATUS_FULL),
         row_checked(CMD_RELEASE, 8'h01, 1'b0, 8'd0, 24'd0, STATUS_RANGE),
         row_checked(CMD_RELEASE, 8'h00, 1'b0, 8'd0, 24'd0, STATUS_OK),
         row_csr(CSR_SLOT_COUNT, 16'd2),
         row_checked(CMD_ALLOC, 8'h00, 1'b1, 8'd0, 24'd0, STATUS_OK),
         row_checked(CMD_ALLOC, 8'h00, 1'b1, 8'd1, 24'd65535, STATUS_OK),
         // No live slots at all: allocate is full and every single release is out of range.
         row_csr(CSR_SLOT_COUNT, 16'd0),
         row_checked(CMD_ALLOC, 8'h00, 1'b0, 8'd0, 24'd0, STATUS_FULL),
         row_checked(CMD_RELEASE, 8'h00, 1'b0, 8'd0, 24'd0, STATUS_RANGE),
         row_checked(CMD_RELEASE_ALL, 8'h00, 1'b0, 8'd0, 24'd0, STATUS_OK),
         // All data bits set: the count register keeps 511, which saturates to 256 slots.
         row_csr(CSR_SLOT_COUNT, 16'hFFFF),
         // Zero-byte objects put every slot at offset zero.
         row_csr(CSR_OBJECT_SIZE, 16'd0),
         row_checked(CMD_ALLOC, 8'h00, 1'b1, 8'd0, 24'd0, STATUS_OK),
         row_checked(CMD_ALLOC, 8'h00, 1'b1, 8'd1, 24'd0, STATUS_OK),
         row_checked(CMD_RELEASE, 8'hFF, 1'b0, 8'd0, 24'd0, STATUS_OK),
         row_csr(CSR_OBJECT_SIZE, 16'h8001),
         row_item(CMD_ALLOC, 8'h00),
         // With 255 live slots the top index is just out of range.
         row_csr(CSR_SLOT_COUNT, 16'd255),
         row_checked(CMD_RELEASE, 8'hFF, 1'b0, 8'd0, 24'd0, STATUS_RANGE)
      };

      // Random phases. The first one has all 256 slots live, the largest object size and mostly
      // allocates, to drive the map towards the top slot, the largest offset and the full case.
      phases.push_back('{256, 65535, 95, 320});
      phases.push_back('{37, 3, 55, 200});
      phases.push_back('{33, -1, 60, 200});
      phases.push_back('{1, -1, 50, 120});
      phases.push_back('{0, -1, 40, 60});
      phases.push_back('{300, -1, 65, 250});
      phases.push_back('{128, 1, 70, 200});
      phases.push_back('{256, -1, 60, 200});

      // Once reset is released the block runs its clearing sweep with busy high, which the
      // first command simply waits out.
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         if (script[i].is_csr) begin
            write_reg(script[i].reg_idx, script[i].reg_val);
         end else begin
            send_item(script[i].req, script[i].typed, script[i].rsp);
            idle_gap(sender_idle_pct());
         end
      end

      // Each phase starts from an idle block, which also makes the sender pause until every
      // result of the previous phase is back.
      foreach (phases[p]) begin
         write_reg(CSR_SLOT_COUNT, CSR_DATA_W'(phases[p].count));
         write_reg(CSR_OBJECT_SIZE, (phases[p].size < 0) ? CSR_DATA_W'($urandom_range(65535))
                                                         : CSR_DATA_W'(phases[p].size));
         repeat (phases[p].items) begin
            send_item(random_req(phases[p].alloc_pct), 1'b0, unused_rsp);
            idle_gap(sender_idle_pct());
         end
      end

      // Let the last results arrive, within a bound, then a short quiet tail.
      start      <= 1'b0;
      drain_wait  = 0;
      while (outcome_q.size() != 0 && drain_wait < 20000) begin
         @(posedge clock);
         drain_wait++;
      end
      if (outcome_q.size() != 0) begin
         $display("%0t ns: results missing, expected %0d more, actual 0",
                  $time, outcome_q.size());
         errors++;
      end
      repeat (20) @(posedge clock);

      $display("Sent %0d commands over %0d register phases; %0d slots granted.",
               item_count, phases.size(), n_granted);
      $display("Saw %0d full and %0d out-of-range answers, largest byte offset %0d.",
               n_full, n_range, top_offset);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog: a correct run needs well under a tenth of this time.
   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
